/* design/multichannel_adc_window_average_top_assert.svh */
// assertion macros shared by the window average block
`ifndef MULTICHANNEL_ADC_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define MULTICHANNEL_ADC_WINDOW_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define MCAW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define MCAW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mcaw_pkg.sv */
// shared types, constants and defaults of the window average block
package mcaw_pkg;

	// defaults for the top level parameters
	localparam int CHANNELS_DEF    = 7;
	localparam int WINDOW_DEF      = 16;
	localparam int SAMPLE_BITS_DEF = 12;

	// fixed port widths
	localparam int SAMPLE_IN_W  = 12;
	localparam int SWITCH_W     = 9;
	localparam int CHAN_OUT_W   = 3;
	localparam int AVG_W        = 12;
	localparam int VOLTS_W      = 18;

	// scaling and saturation
	localparam int                 VOLT_SCALE   = 33;
	localparam int                 VOLT_SCALE_W = 6;
	localparam logic [AVG_W-1:0]   AVG_MAX      = 12'hFFF;
	localparam logic [VOLTS_W-1:0] VOLTS_MAX    = 18'h3FFFF;

	// depth of the queues between the parts
	localparam int QUEUE_DEPTH = 2;

	// tri-state switch status codes
	localparam logic signed [1:0] ST_NOK  = -2'sd1;
	localparam logic signed [1:0] ST_OK   = 2'sd1;
	localparam logic signed [1:0] ST_NONE = 2'sd0;

	// decoded switch statuses
	typedef struct packed {
		logic              start_pressed;
		logic signed [1:0] prog_status;
		logic signed [1:0] rgb_status;
		logic signed [1:0] motor_status;
		logic signed [1:0] buzzer_status;
	} sw_status_t;

	// one result transaction
	typedef struct packed {
		logic [CHAN_OUT_W-1:0] channel;
		logic [AVG_W-1:0]      average_code;
		logic [VOLTS_W-1:0]    volts_q16;
		sw_status_t            st;
		logic                  last;
	} result_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_UPDATE,
		BK_EMIT_RD,
		BK_EMIT_MUL,
		BK_EMIT_OUT
	} back_state_t;

endpackage

/* design/mcaw_fifo.sv */
// small synchronous queue used between the parts of the block
module mcaw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mcaw_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// handshake qualification
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/mcaw_front.sv */
// front end: tags each conversion with its channel and decodes the switch pins
module mcaw_front #(
	parameter int CHANNELS    = mcaw_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = mcaw_pkg::SAMPLE_BITS_DEF,
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [mcaw_pkg::SAMPLE_IN_W-1:0] sample,
	input  logic [mcaw_pkg::SWITCH_W-1:0]    switch_levels,
	output logic [CH_W-1:0]                  item_chan,
	output logic [SAMPLE_BITS-1:0]           item_sample,
	output logic                             item_last,
	output mcaw_pkg::sw_status_t             item_st
);

	logic [CH_W-1:0] chan_q;

	// one ok/nok pin pair, nok wins
	function automatic logic signed [1:0] pair_status(input logic ok_n, input logic nok_n);
		logic signed [1:0] st;
		if (!nok_n) begin
			st = mcaw_pkg::ST_NOK;
		end else if (!ok_n) begin
			st = mcaw_pkg::ST_OK;
		end else begin
			st = mcaw_pkg::ST_NONE;
		end
		return st;
	endfunction

	// classify the incoming transaction
	always_comb begin
		item_chan                   = chan_q;
		item_last                   = (chan_q == CH_W'(CHANNELS - 1));
		item_sample                 = SAMPLE_BITS'(sample);
		item_st.start_pressed       = !switch_levels[0];
		item_st.prog_status         = pair_status(switch_levels[1], switch_levels[2]);
		item_st.rgb_status          = pair_status(switch_levels[3], switch_levels[4]);
		item_st.motor_status        = pair_status(switch_levels[5], switch_levels[6]);
		item_st.buzzer_status       = pair_status(switch_levels[7], switch_levels[8]);
	end

	// round-robin channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
		end else if (accept) begin
			chan_q <= item_last ? '0 : chan_q + 1'b1;
		end
	end

endmodule

/* design/mcaw_back.sv */
// back end: window store, running sums, averaging and result sequencing
`include "multichannel_adc_window_average_top_assert.svh"

module mcaw_back #(
	parameter int CHANNELS    = mcaw_pkg::CHANNELS_DEF,
	parameter int WINDOW      = mcaw_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = mcaw_pkg::SAMPLE_BITS_DEF,
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  logic [CH_W-1:0]        q_chan,
	input  logic [SAMPLE_BITS-1:0] q_sample,
	input  logic                   q_last,
	input  mcaw_pkg::sw_status_t   q_st,
	input  logic                   out_full,
	output logic                   out_push,
	output mcaw_pkg::result_t      out_res
);

	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int ADDR_W  = $clog2(CHANNELS * WINDOW);
	localparam int SUM_W   = SAMPLE_BITS + SLOT_W;
	localparam int SHIFT   = SUM_W + SLOT_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);
	localparam int AX_W = (SAMPLE_BITS > mcaw_pkg::AVG_W) ? SAMPLE_BITS : mcaw_pkg::AVG_W;
	localparam int VP_W = SAMPLE_BITS + mcaw_pkg::VOLT_SCALE_W;
	localparam int VX_W = (VP_W > mcaw_pkg::VOLTS_W) ? VP_W : mcaw_pkg::VOLTS_W;

	mcaw_pkg::back_state_t state_q;
	mcaw_pkg::back_state_t state_d;

	// current item
	logic [CH_W-1:0]        cur_chan_q;
	logic [SAMPLE_BITS-1:0] cur_sample_q;
	logic                   cur_last_q;
	mcaw_pkg::sw_status_t   cur_st_q;
	logic [ADDR_W-1:0]      cur_addr_q;

	// window position and fill tracking
	logic [SLOT_W-1:0]   slot_q;
	logic                wrapped_q;
	logic [CHANNELS-1:0] sum_vld_q;
	logic [CH_W-1:0]     emit_q;

	// memories and their read registers
	logic [SAMPLE_BITS-1:0] smem [CHANNELS * WINDOW];
	logic [SAMPLE_BITS-1:0] smem_rd_q;
	logic [SUM_W-1:0]       sum_mem [CHANNELS];
	logic [SUM_W-1:0]       sum_rd_q;
	logic                   sum_vld_rd_q;
	logic [PROD_W-1:0]      prod_q;

	// control decoded from the state
	logic              update_en;
	logic              mul_en;
	logic [CH_W-1:0]   sum_raddr;
	logic [ADDR_W-1:0] q_addr;

	// datapath
	logic                   emit_last;
	logic                   slot_last;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_cur;
	logic [SUM_W-1:0]       sum_new;
	logic [PROD_W-1:0]      prod_d;
	logic [SAMPLE_BITS-1:0] avg_raw;
	logic [AX_W-1:0]        avg_x;
	logic [VX_W-1:0]        volts_x;

	assign q_addr    = ADDR_W'(ADDR_W'(q_chan) * ADDR_W'(WINDOW)) + ADDR_W'(slot_q);
	assign emit_last = (emit_q == CH_W'(CHANNELS - 1));
	assign slot_last = (slot_q == SLOT_W'(WINDOW - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcaw_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = mcaw_pkg::BK_UPDATE;
				end
			end
			mcaw_pkg::BK_UPDATE: begin
				state_d = cur_last_q ? mcaw_pkg::BK_EMIT_RD : mcaw_pkg::BK_IDLE;
			end
			mcaw_pkg::BK_EMIT_RD: begin
				state_d = mcaw_pkg::BK_EMIT_MUL;
			end
			mcaw_pkg::BK_EMIT_MUL: begin
				state_d = mcaw_pkg::BK_EMIT_OUT;
			end
			mcaw_pkg::BK_EMIT_OUT: begin
				if (!out_full) begin
					state_d = emit_last ? mcaw_pkg::BK_IDLE : mcaw_pkg::BK_EMIT_RD;
				end
			end
			default: begin
				state_d = mcaw_pkg::BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		update_en = 1'b0;
		mul_en    = 1'b0;
		out_push  = 1'b0;
		sum_raddr = emit_q;
		case (state_q)
			mcaw_pkg::BK_IDLE: begin
				q_pop     = !q_empty;
				sum_raddr = q_chan;
			end
			mcaw_pkg::BK_UPDATE: begin
				update_en = 1'b1;
			end
			mcaw_pkg::BK_EMIT_RD: begin
				sum_raddr = emit_q;
			end
			mcaw_pkg::BK_EMIT_MUL: begin
				mul_en = 1'b1;
			end
			mcaw_pkg::BK_EMIT_OUT: begin
				out_push = !out_full;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// running sum update: add the new sample, drop the one it replaces
	always_comb begin
		old_sample = wrapped_q ? smem_rd_q : '0;
		sum_cur    = sum_vld_rd_q ? sum_rd_q : '0;
		sum_new    = sum_cur + SUM_W'(cur_sample_q) - SUM_W'(old_sample);
	end

	// divide by the window length through a reciprocal multiply
	assign prod_d  = PROD_W'(sum_cur) * PROD_W'(RECIP);
	assign avg_raw = prod_q[SHIFT +: SAMPLE_BITS];
	assign avg_x   = AX_W'(avg_raw);
	assign volts_x = VX_W'(avg_raw) * VX_W'(mcaw_pkg::VOLT_SCALE);

	// result assembly with saturation
	always_comb begin
		out_res.channel      = mcaw_pkg::CHAN_OUT_W'(emit_q);
		out_res.average_code = (avg_x > AX_W'(mcaw_pkg::AVG_MAX)) ?
			mcaw_pkg::AVG_MAX : avg_x[mcaw_pkg::AVG_W-1:0];
		out_res.volts_q16    = (volts_x > VX_W'(mcaw_pkg::VOLTS_MAX)) ?
			mcaw_pkg::VOLTS_MAX : volts_x[mcaw_pkg::VOLTS_W-1:0];
		out_res.st           = cur_st_q;
		out_res.last         = emit_last;
	end

	// sample window memory
	always_ff @(posedge clk) begin
		if (update_en) begin
			smem[cur_addr_q] <= cur_sample_q;
		end
		smem_rd_q <= smem[q_addr];
	end

	// running sum memory
	always_ff @(posedge clk) begin
		if (update_en) begin
			sum_mem[cur_chan_q] <= sum_new;
		end
		sum_rd_q <= sum_mem[sum_raddr];
	end

	// item capture and product register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_chan_q   <= q_chan;
			cur_sample_q <= q_sample;
			cur_last_q   <= q_last;
			cur_st_q     <= q_st;
			cur_addr_q   <= q_addr;
		end
		if (mul_en) begin
			prod_q <= prod_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mcaw_pkg::BK_IDLE;
			slot_q       <= '0;
			wrapped_q    <= 1'b0;
			sum_vld_q    <= '0;
			sum_vld_rd_q <= 1'b0;
			emit_q       <= '0;
		end else begin
			state_q      <= state_d;
			sum_vld_rd_q <= sum_vld_q[sum_raddr];
			if (update_en) begin
				sum_vld_q[cur_chan_q] <= 1'b1;
				if (cur_last_q) begin
					slot_q <= slot_last ? '0 : slot_q + 1'b1;
					emit_q <= '0;
					if (slot_last) begin
						wrapped_q <= 1'b1;
					end
				end
			end
			if (out_push && !emit_last) begin
				emit_q <= emit_q + 1'b1;
			end
		end
	end

	// checks
	`MCAW_ASSERT_NOW(a_push_has_room, out_push, !out_full, "result pushed into a full queue")
	`MCAW_ASSERT_NOW(a_pop_when_idle, q_pop, state_q == mcaw_pkg::BK_IDLE && !q_empty, "item popped outside idle")
	`MCAW_ASSERT_NEXT(a_scan_end_emits, state_q == mcaw_pkg::BK_UPDATE && cur_last_q, state_q == mcaw_pkg::BK_EMIT_RD && emit_q == '0, "scan end did not start emission")
	`MCAW_ASSERT_NEXT(a_emit_done, out_push && emit_last, state_q == mcaw_pkg::BK_IDLE, "emission did not stop after the last channel")

endmodule

/* design/multichannel_adc_window_average_top.sv */
// Multichannel ADC window average. Conversions enter in round-robin channel order
// (CHANNELS per scan); each goes into a WINDOW-deep per-channel window, cleared at
// reset so early averages include zeros. The transaction for the last channel of
// a scan advances the window slot and yields CHANNELS results in channel order,
// each with the truncated window average, the average times 33 in Q.16 volts, and
// the switch statuses decoded from that transaction's pins. A running sum per
// channel is kept, so each conversion takes a memory read, then a sum update and
// write; the scan's last conversion then adds, per result, a sum read, a
// reciprocal multiply and an output push that waits while the result queue is
// full. Small queues on both sides let input and output stall independently;
// no clearing pass is needed after reset.
module multichannel_adc_window_average_top #(
	parameter int CHANNELS    = mcaw_pkg::CHANNELS_DEF,
	parameter int WINDOW      = mcaw_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = mcaw_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic        [mcaw_pkg::SAMPLE_IN_W-1:0] sample,
	input  logic        [mcaw_pkg::SWITCH_W-1:0]    switch_levels,
	output logic                                   empty,
	input  logic                                   pop,
	output logic        [mcaw_pkg::CHAN_OUT_W-1:0]  channel,
	output logic        [mcaw_pkg::AVG_W-1:0]       average_code,
	output logic        [mcaw_pkg::VOLTS_W-1:0]     volts_q16,
	output logic                                   start_pressed,
	output logic signed [1:0]                      prog_status,
	output logic signed [1:0]                      rgb_status,
	output logic signed [1:0]                      motor_status,
	output logic signed [1:0]                      buzzer_status,
	output logic                                   last
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ST_W  = $bits(mcaw_pkg::sw_status_t);
	localparam int MID_W = CH_W + SAMPLE_BITS + 1 + ST_W;
	localparam int RES_W = $bits(mcaw_pkg::result_t);

	// front end outputs
	logic [CH_W-1:0]        f_chan;
	logic [SAMPLE_BITS-1:0] f_sample;
	logic                   f_last;
	mcaw_pkg::sw_status_t   f_st;

	// queue between front and back
	logic [MID_W-1:0]       mid_wdata;
	logic [MID_W-1:0]       mid_rdata;
	logic                   mid_empty;
	logic                   mid_pop;
	logic [CH_W-1:0]        b_chan;
	logic [SAMPLE_BITS-1:0] b_sample;
	logic                   b_last;
	mcaw_pkg::sw_status_t   b_st;

	// result queue
	logic                   res_full;
	logic                   res_push;
	mcaw_pkg::result_t      res_in;
	logic [RES_W-1:0]       res_rdata;
	mcaw_pkg::result_t      res_out;

	// front end
	mcaw_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (push && !full),
		.sample        (sample),
		.switch_levels (switch_levels),
		.item_chan     (f_chan),
		.item_sample   (f_sample),
		.item_last     (f_last),
		.item_st       (f_st)
	);

	assign mid_wdata = {f_chan, f_sample, f_last, f_st};

	// classified item queue
	mcaw_fifo #(
		.WIDTH (MID_W),
		.DEPTH (mcaw_pkg::QUEUE_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (mid_wdata),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign {b_chan, b_sample, b_last, b_st} = mid_rdata;

	// back end
	mcaw_back #(
		.CHANNELS    (CHANNELS),
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mid_empty),
		.q_pop    (mid_pop),
		.q_chan   (b_chan),
		.q_sample (b_sample),
		.q_last   (b_last),
		.q_st     (b_st),
		.out_full (res_full),
		.out_push (res_push),
		.out_res  (res_in)
	);

	// result queue
	mcaw_fifo #(
		.WIDTH (RES_W),
		.DEPTH (mcaw_pkg::QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (RES_W'(res_in)),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	// result ports
	assign res_out       = mcaw_pkg::result_t'(res_rdata);
	assign channel       = res_out.channel;
	assign average_code  = res_out.average_code;
	assign volts_q16     = res_out.volts_q16;
	assign start_pressed = res_out.st.start_pressed;
	assign prog_status   = res_out.st.prog_status;
	assign rgb_status    = res_out.st.rgb_status;
	assign motor_status  = res_out.st.motor_status;
	assign buzzer_status = res_out.st.buzzer_status;
	assign last          = res_out.last;

endmodule

/* tb/tb_multichannel_adc_window_average_top.sv */
// self-checking testbench for the multichannel adc window average block
module tb_multichannel_adc_window_average_top;
	import mcaw_pkg::*;

	// block configuration under test
	localparam int NUM_CH      = CHANNELS_DEF;
	localparam int WIN_LEN     = WINDOW_DEF;
	localparam int SAMPLE_MASK = (1 << SAMPLE_BITS_DEF) - 1;

	// run control
	localparam int TAIL_CYCLES = 100;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int LONG_HOLD   = 600;

	// active-low pin positions
	localparam int PIN_START     = 0;
	localparam int PIN_PROG_OK   = 1;
	localparam int PIN_RGB_OK    = 3;
	localparam int PIN_MOTOR_OK  = 5;
	localparam int PIN_BUZZER_OK = 7;

	// pin patterns for the directed scans
	localparam logic [SWITCH_W-1:0] PINS_ALL_LOW = 9'h000;
	localparam logic [SWITCH_W-1:0] PINS_OK_LOW  = 9'h154;
	localparam logic [SWITCH_W-1:0] PINS_MIXED   = 9'h1B9;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	logic [SAMPLE_IN_W-1:0] sample        = '0;
	logic [SWITCH_W-1:0]    switch_levels = '1;
	logic                   full;
	logic                   empty;
	logic [CHAN_OUT_W-1:0]  channel;
	logic [AVG_W-1:0]       average_code;
	logic [VOLTS_W-1:0]     volts_q16;
	logic                   start_pressed;
	logic signed [1:0]      prog_status;
	logic signed [1:0]      rgb_status;
	logic signed [1:0]      motor_status;
	logic signed [1:0]      buzzer_status;
	logic                   last;

	// predictor state
	logic [SAMPLE_IN_W-1:0] window_mem [NUM_CH][WIN_LEN];
	int unsigned scan_ch  = 0;
	int unsigned slot_idx = 0;
	result_t     avg_expect_q [$];

	// traffic shaping and bookkeeping
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int rx_hold_req   = 0;
	int rx_hold_left  = 0;
	int err_count     = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int cycle_count   = 0;

	multichannel_adc_window_average_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.switch_levels (switch_levels),
		.empty         (empty),
		.pop           (pop),
		.channel       (channel),
		.average_code  (average_code),
		.volts_q16     (volts_q16),
		.start_pressed (start_pressed),
		.prog_status   (prog_status),
		.rgb_status    (rgb_status),
		.motor_status  (motor_status),
		.buzzer_status (buzzer_status),
		.last          (last)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, avg_expect_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// tri-state decode of one ok/nok pin pair, nok wins
	function automatic logic signed [1:0] pair_state(logic [SWITCH_W-1:0] levels, int ok_bit);
		if (!levels[ok_bit + 1])
			return ST_NOK;
		if (!levels[ok_bit])
			return ST_OK;
		return ST_NONE;
	endfunction

	// store one conversion, on the scan's last channel queue a result per channel
	task automatic predict_conversion(input logic [SAMPLE_IN_W-1:0] s,
			input logic [SWITCH_W-1:0] levels);
		result_t     r;
		int unsigned sum;
		int unsigned avg;
		int unsigned volts;
		int          c;
		int          k;
		window_mem[scan_ch][slot_idx] = SAMPLE_IN_W'(s & SAMPLE_MASK);
		if (scan_ch != NUM_CH - 1) begin
			scan_ch++;
		end else begin
			scan_ch  = 0;
			slot_idx = (slot_idx + 1) % WIN_LEN;
			for (c = 0; c < NUM_CH; c++) begin
				sum = 0;
				for (k = 0; k < WIN_LEN; k++)
					sum += window_mem[c][k];
				avg   = sum / WIN_LEN;
				volts = avg * VOLT_SCALE;
				if (avg > AVG_MAX)
					avg = 32'(AVG_MAX);
				if (volts > VOLTS_MAX)
					volts = 32'(VOLTS_MAX);
				r.channel          = CHAN_OUT_W'(c);
				r.average_code     = AVG_W'(avg);
				r.volts_q16        = VOLTS_W'(volts);
				r.st.start_pressed = !levels[PIN_START];
				r.st.prog_status   = pair_state(levels, PIN_PROG_OK);
				r.st.rgb_status    = pair_state(levels, PIN_RGB_OK);
				r.st.motor_status  = pair_state(levels, PIN_MOTOR_OK);
				r.st.buzzer_status = pair_state(levels, PIN_BUZZER_OK);
				r.last             = (c == NUM_CH - 1);
				avg_expect_q.push_back(r);
			end
		end
	endtask

	task automatic note_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v)
			note_mismatch($sformatf("result %0d %s expected %0d got %0d",
				results_seen, name, exp_v, act_v));
	endtask

	// compare the popped transaction with the oldest expectation
	task automatic check_result();
		result_t exp_r;
		if (avg_expect_q.size() == 0) begin
			note_mismatch($sformatf("result for channel %0d with nothing expected", channel));
		end else begin
			exp_r = avg_expect_q.pop_front();
			check_field("channel", int'(exp_r.channel), int'(channel));
			check_field("average_code", int'(exp_r.average_code), int'(average_code));
			check_field("volts_q16", int'(exp_r.volts_q16), int'(volts_q16));
			check_field("start_pressed", int'(exp_r.st.start_pressed), int'(start_pressed));
			check_field("prog_status", int'($signed(exp_r.st.prog_status)),
				int'($signed(prog_status)));
			check_field("rgb_status", int'($signed(exp_r.st.rgb_status)),
				int'($signed(rgb_status)));
			check_field("motor_status", int'($signed(exp_r.st.motor_status)),
				int'($signed(motor_status)));
			check_field("buzzer_status", int'($signed(exp_r.st.buzzer_status)),
				int'($signed(buzzer_status)));
			check_field("last", int'(exp_r.last), int'(last));
		end
		results_seen++;
	endtask

	// receiver: check accepted results, then pick pop for the next cycle
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result();
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// offer one conversion and hold it until accepted
	task automatic send_conversion(input logic [SAMPLE_IN_W-1:0] s,
			input logic [SWITCH_W-1:0] levels);
		if ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		push          <= 1'b1;
		sample        <= s;
		switch_levels <= levels;
		do @(posedge clk); while (full);
		predict_conversion(s, levels);
		items_sent++;
	endtask

	// stop offering until every expected result is in, then let the back end settle
	task automatic wait_for_drain();
		push <= 1'b0;
		while (avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// sample mix weighted toward the code extremes
	function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return SAMPLE_IN_W'($urandom);
			end
		endcase
	endfunction

	// window cleared at reset: a full-scale scan averages to a sixteenth
	task automatic test_reset_window();
		int i;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		for (i = 0; i < NUM_CH; i++)
			send_conversion('1, (i == NUM_CH - 1) ? PINS_MIXED : SWITCH_W'($urandom));
	endtask

	// all pins low, then only ok pins low with start pressed
	task automatic test_switch_decode();
		logic [SAMPLE_IN_W-1:0] ramp [NUM_CH];
		int i;
		ramp = '{12'd1, 12'd4094, 12'd2048, 12'd2047, 12'd1365, 12'd2730, 12'd16};
		for (i = 0; i < NUM_CH; i++)
			send_conversion('0, (i == NUM_CH - 1) ? PINS_ALL_LOW : SWITCH_W'($urandom));
		for (i = 0; i < NUM_CH; i++)
			send_conversion(ramp[i], (i == NUM_CH - 1) ? PINS_OK_LOW : SWITCH_W'($urandom));
		wait_for_drain();
	endtask

	// fill every window with full scale, then empty it again
	task automatic test_full_scale_window();
		int i;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		for (i = 0; i < NUM_CH * WIN_LEN; i++)
			send_conversion('1, SWITCH_W'($urandom));
		for (i = 0; i < NUM_CH * WIN_LEN; i++)
			send_conversion('0, SWITCH_W'($urandom));
		wait_for_drain();
	endtask

	// random conversions under one idling mix
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
		int i;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (i = 0; i < count; i++)
			send_conversion(pick_sample(), SWITCH_W'($urandom));
		wait_for_drain();
	endtask

	// long receiver hold while the sender keeps pushing, so both queues fill
	task automatic test_backpressure();
		int i;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_req  = LONG_HOLD;
		for (i = 0; i < NUM_CH * 7; i++)
			send_conversion(pick_sample(), SWITCH_W'($urandom));
		wait_for_drain();
	endtask

	// test sequence
	initial begin
		foreach (window_mem[c, k])
			window_mem[c][k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_switch_decode();
		test_full_scale_window();
		test_random_traffic(0, 0, 35);
		test_random_traffic(65, 0, 35);
		test_random_traffic(0, 65, 35);
		test_random_traffic(21, 21, 35);
		test_backpressure();
		$display("covered %0d conversions and %0d checked results in %0d cycles",
			items_sent, results_seen, cycle_count);
		$display("including reset-cleared and full-scale windows, all pin decodes and a long output stall");
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", err_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
